// ----- sv/bqc_pkg.sv -----
// ----------------------------------------------------------------------------
// bqc_pkg
// shared types, coefficient table and saturation helpers for the biquad cascade
// ----------------------------------------------------------------------------
package bqc_pkg;

  localparam int SECTIONS  = 4;
  localparam int MODES     = 4;
  localparam int WORD_W    = 40;
  localparam int ACC_W     = 47;
  localparam int TERM_W    = 44;
  localparam int FULL_W    = 72;
  localparam int PART_W    = 56;

  typedef logic signed [31:0]       coef_t;
  typedef logic signed [WORD_W-1:0] dword_t;

  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  // word handed from one section to the next
  typedef struct packed {
    logic   vld;
    dword_t data;
  } bqc_link_t;

  typedef struct packed {
    logic [11:0] sample_in;
    logic [1:0]  channel_sel;
  } bqc_in_t;

  typedef struct packed {
    logic signed [15:0] filtered_out;
    logic [1:0]         channel_out;
  } bqc_out_t;

  // decimal constant scaled by 1e8 into q4.28, rounded half away from zero
  function automatic coef_t qc(longint n);
    longint r;
    r = (n * 64'sd268435456 + 64'sd50000000) / 64'sd100000000;
    return coef_t'(r);
  endfunction

  localparam coef_set_t COEF_TAB [MODES][SECTIONS] = '{
    '{ // muscle
      '{qc(1856301), qc(3712602), qc(1856301), qc(5159732), qc(36347401)},
      '{qc(100000000), -qc(200000000), qc(100000000), -qc(53945795), qc(39764934)},
      '{qc(100000000), qc(200000000), qc(100000000), qc(47319594), qc(70744137)},
      '{qc(100000000), -qc(200000000), qc(100000000), -qc(100211112), qc(74520226)}},
    '{ // brain
      '{qc(71374), qc(142749), qc(71374), -qc(141361551), qc(51060681)},
      '{qc(100000000), qc(200000000), qc(100000000), -qc(164480745), qc(76352964)},
      '{qc(100000000), -qc(200000000), qc(100000000), -qc(198813960), qc(98818120)},
      '{qc(100000000), -qc(200000000), qc(100000000), -qc(199527805), qc(99531780)}},
    '{ // eye
      '{qc(15141), qc(30282), qc(15141), -qc(160403273), qc(64913439)},
      '{qc(100000000), qc(200000000), qc(100000000), -qc(178372179), qc(83788559)},
      '{qc(100000000), -qc(200000000), qc(100000000), -qc(198799122), qc(98803414)},
      '{qc(100000000), -qc(200000000), qc(100000000), -qc(199533934), qc(99537927)}},
    '{ // heart
      '{qc(311190), qc(622381), qc(311190), -qc(115206017), qc(35073306)},
      '{qc(100000000), qc(200000000), qc(100000000), -qc(141577490), qc(66846960)},
      '{qc(100000000), -qc(200000000), qc(100000000), -qc(198823710), qc(98827786)},
      '{qc(100000000), -qc(200000000), qc(100000000), -qc(199523783), qc(99527746)}}
  };

  function automatic dword_t sat40(logic signed [ACC_W-1:0] v);
    if (v > 47'sd549755813887) return 40'sh7F_FFFF_FFFF;
    else if (v < -47'sd549755813888) return 40'sh80_0000_0000;
    else return v[WORD_W-1:0];
  endfunction

  // floor to integer and clip to 16 bits
  function automatic logic signed [15:0] sat16(dword_t v);
    logic signed [23:0] i;
    i = v[WORD_W-1:16];
    if (i > 24'sd32767) return 16'sh7FFF;
    else if (i < -24'sd32768) return 16'sh8000;
    else return i[15:0];
  endfunction

endpackage

// ----- sv/biopotential_biquad_cascade_core.sv -----
// ----------------------------------------------------------------------------
// biopotential_biquad_cascade_core
// four-section biquad cascade filter for multichannel biopotential samples
// ----------------------------------------------------------------------------
// usage
// - input channel: in_valid / in_stall / in_word carries a raw adc sample and
//   its channel number; one word is taken at a time, in_stall stays high from
//   acceptance until the result has moved into the output register
// - output channel: out_valid / out_stall / out_word returns the filtered,
//   16-bit saturated sample and its channel; a stalled word holds steady
// - each of the four section cells runs five 32x40 products through one split
//   32x24 multiplier, each product as a low partial, a high partial, a combine
//   and an accumulate step, plus a saturation and a write-back step; the cells
//   work one after another
// - an out-of-range channel skips the cells and returns zero
// - cfg_we / cfg_wdata writes the band select; write only while idle
// - reset (rst_n low, synchronous) clears all delay words, the band select and
//   the handshake state
// - while the receiver stalls, the finished result waits and no new word is
//   taken until it has moved into the output register
// ----------------------------------------------------------------------------
module biopotential_biquad_cascade_core
  import bqc_pkg::*;
#(
  parameter int CHANNELS    = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bqc_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output bqc_out_t out_word,
  input  logic     cfg_we,
  input  logic [1:0] cfg_wdata
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [1:0]        mode_r;
  logic              busy_r, pend_r, start_r, out_valid_r;
  logic [1:0]        chan_r;
  logic [CH_W-1:0]   ch_idx_r;
  dword_t            x_r;
  logic signed [15:0] res_r;
  bqc_out_t          out_word_r;
  bqc_link_t         link [SECTIONS+1];
  logic              accept, ch_ok;
  logic [15:0]       raw;

  assign accept = in_valid && !in_stall;
  assign ch_ok  = (32'(in_word.channel_sel) < CHANNELS);
  // keep only the low sample bits
  assign raw = 16'(in_word.sample_in) & 16'((32'd1 << SAMPLE_BITS) - 32'd1);

  assign link[0].vld  = start_r;
  assign link[0].data = x_r;

  // row of section cells, each one feeding the next
  for (genvar s = 0; s < SECTIONS; s++) begin : g_sec
    bqc_section #(.CHANNELS(CHANNELS), .CH_W(CH_W)) u_sec (
      .clk     (clk),
      .rst_n   (rst_n),
      .link_in (link[s]),
      .ch_idx  (ch_idx_r),
      .coefs   (COEF_TAB[mode_r][s]),
      .link_out(link[s+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      // one-cycle kick into the first cell for a valid channel
      start_r <= accept && ch_ok;
      if (accept) begin
        busy_r   <= 1'b1;
        chan_r   <= in_word.channel_sel;
        ch_idx_r <= CH_W'(32'(in_word.channel_sel));
        x_r      <= $signed({8'd0, raw, 16'd0});
        if (!ch_ok) begin
          // invalid channel: result is zero, no delay words touched
          res_r  <= '0;
          pend_r <= 1'b1;
        end
      end
      if (link[SECTIONS].vld) begin
        res_r  <= sat16(link[SECTIONS].data);
        pend_r <= 1'b1;
      end
      // move finished result into the output register once it is free
      if (pend_r && (!out_valid_r || !out_stall)) begin
        out_word_r.filtered_out <= res_r;
        out_word_r.channel_out  <= chan_r;
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
        busy_r      <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = busy_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- sv/bqc_section.sv -----
// ----------------------------------------------------------------------------
// bqc_section
// one direct-form-ii biquad cell with per-channel delay words and its own
// split multiplier
// ----------------------------------------------------------------------------
module bqc_section
  import bqc_pkg::*;
#(
  parameter int CHANNELS = 4,
  parameter int CH_W     = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bqc_link_t       link_in,
  input  logic [CH_W-1:0] ch_idx,
  input  coef_set_t       coefs,
  output bqc_link_t       link_out
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MLO  = 7'b0000010,
    S_MHI  = 7'b0000100,
    S_CMB  = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_WSAT = 7'b0100000,
    S_DONE = 7'b1000000
  } sec_state_t;

  localparam logic [2:0] K_A1 = 3'd0;
  localparam logic [2:0] K_A2 = 3'd1;
  localparam logic [2:0] K_B1 = 3'd2;
  localparam logic [2:0] K_B2 = 3'd3;
  localparam logic [2:0] K_B0 = 3'd4;

  sec_state_t st_r, st_nxt;
  logic [2:0] k_r;
  logic [CH_W-1:0] ch_r;
  dword_t z1_r, z2_r, w_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PART_W-1:0] p_r;
  logic signed [FULL_W-1:0] full_r;
  dword_t store_r [CHANNELS][2];

  coef_t  c_sel;
  dword_t d_sel;
  logic signed [TERM_W-1:0] term;

  always_comb begin
    case (k_r)
      K_A1: begin c_sel = coefs.a1; d_sel = z1_r; end
      K_A2: begin c_sel = coefs.a2; d_sel = z2_r; end
      K_B1: begin c_sel = coefs.b1; d_sel = z1_r; end
      K_B2: begin c_sel = coefs.b2; d_sel = z2_r; end
      default: begin c_sel = coefs.b0; d_sel = w_r; end
    endcase
  end

  assign term = full_r[FULL_W-1:28];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (link_in.vld) st_nxt = S_MLO;
      S_MLO:  st_nxt = S_MHI;
      S_MHI:  st_nxt = S_CMB;
      S_CMB:  st_nxt = S_ACC;
      S_ACC: begin
        if (k_r == K_A2) st_nxt = S_WSAT;
        else if (k_r == K_B0) st_nxt = S_DONE;
        else st_nxt = S_MLO;
      end
      S_WSAT: st_nxt = S_MLO;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      k_r  <= K_A1;
      for (int c = 0; c < CHANNELS; c++) begin
        store_r[c][0] <= '0;
        store_r[c][1] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_IDLE: if (link_in.vld) begin
          acc_r <= ACC_W'(link_in.data);
          z1_r  <= store_r[ch_idx][0];
          z2_r  <= store_r[ch_idx][1];
          ch_r  <= ch_idx;
          k_r   <= K_A1;
        end
        S_MLO: p_r <= PART_W'(c_sel * $signed({1'b0, d_sel[15:0]}));
        S_MHI: begin
          full_r <= FULL_W'(p_r);
          p_r    <= PART_W'(c_sel * $signed(d_sel[WORD_W-1:16]));
        end
        // add high partial product and the half-lsb rounding constant
        S_CMB: full_r <= full_r + (FULL_W'(p_r) <<< 16) + FULL_W'(1 << 27);
        S_ACC: begin
          if (k_r == K_A1 || k_r == K_A2) acc_r <= acc_r - ACC_W'(term);
          else acc_r <= acc_r + ACC_W'(term);
          if (k_r != K_A2 && k_r != K_B0) k_r <= k_r + 3'd1;
        end
        S_WSAT: begin
          w_r   <= sat40(acc_r);
          acc_r <= '0;
          k_r   <= K_B1;
        end
        S_DONE: begin
          store_r[ch_r][0] <= w_r;
          store_r[ch_r][1] <= z1_r;
          k_r <= K_A1;
        end
        default: ;
      endcase
    end
  end

  assign link_out.vld  = (st_r == S_DONE);
  assign link_out.data = sat40(acc_r);

endmodule

// ----- sv/bqc_checker.sv -----
// ----------------------------------------------------------------------------
// bqc_checker
// port-level checks on the biquad cascade handshakes
// ----------------------------------------------------------------------------
module bqc_checker
  import bqc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input bqc_out_t out_word
);

  // one word at a time: input closes right after acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

endmodule

bind biopotential_biquad_cascade_core bqc_checker u_bqc_checker (.*);

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the four-section biquad cascade core: a bit-exact
// cascade predictor in the scoreboard is compared against every result word,
// over all four bands, under several sender idle and receiver stall mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bqc_pkg::*;

  // scoreboard: keeps its own delay words and band select, predicts the
  // filtered sample at input acceptance, checks result words in order
  class cascade_scoreboard;
    logic signed [31:0] coef[4][4][5];   // band, section, b0 b1 b2 a1 a2
    logic signed [39:0] dly[4][4][2];    // channel, section, z1 z2
    logic [1:0]         band;
    bqc_out_t           expected_q[$];
    int                 errors;

    function new();
      // band constants scaled by 1e8
      longint raw_tab[4][4][5] = '{
        '{'{1856301, 3712602, 1856301, 5159732, 36347401},
          '{100000000, -200000000, 100000000, -53945795, 39764934},
          '{100000000, 200000000, 100000000, 47319594, 70744137},
          '{100000000, -200000000, 100000000, -100211112, 74520226}},
        '{'{71374, 142749, 71374, -141361551, 51060681},
          '{100000000, 200000000, 100000000, -164480745, 76352964},
          '{100000000, -200000000, 100000000, -198813960, 98818120},
          '{100000000, -200000000, 100000000, -199527805, 99531780}},
        '{'{15141, 30282, 15141, -160403273, 64913439},
          '{100000000, 200000000, 100000000, -178372179, 83788559},
          '{100000000, -200000000, 100000000, -198799122, 98803414},
          '{100000000, -200000000, 100000000, -199533934, 99537927}},
        '{'{311190, 622381, 311190, -115206017, 35073306},
          '{100000000, 200000000, 100000000, -141577490, 66846960},
          '{100000000, -200000000, 100000000, -198823710, 98827786},
          '{100000000, -200000000, 100000000, -199523783, 99527746}}};
      longint mag;
      longint q;
      for (int m = 0; m < 4; m++)
        for (int s = 0; s < 4; s++)
          for (int k = 0; k < 5; k++) begin
            mag = (raw_tab[m][s][k] < 0) ? -raw_tab[m][s][k] : raw_tab[m][s][k];
            // q4.28, half away from zero
            q = (mag * 268435456 + 50000000) / 100000000;
            coef[m][s][k] = (raw_tab[m][s][k] < 0) ? -q : q;
          end
      foreach (dly[c, s, z]) dly[c][s][z] = '0;
      band = 2'd0;
      errors = 0;
    endfunction

    function automatic logic signed [39:0] clip40(logic signed [79:0] v);
      if (v > 80'sd549755813887) return 40'sh7F_FFFF_FFFF;
      if (v < -80'sd549755813888) return 40'sh80_0000_0000;
      return v[39:0];
    endfunction

    // coefficient times word, rounded half up to 16 fractional bits
    function automatic logic signed [79:0] qmul(logic signed [31:0] c,
                                                logic signed [39:0] d);
      logic signed [79:0] p;
      p = c * d;
      return (p + (80'sd1 <<< 27)) >>> 28;
    endfunction

    function void note_input(bqc_in_t w);
      logic signed [79:0] x;
      logic signed [39:0] wv;
      logic signed [39:0] yv;
      logic signed [39:0] z1;
      logic signed [39:0] z2;
      logic signed [23:0] ip;
      bqc_out_t r;
      x = {52'd0, w.sample_in, 16'd0};
      for (int s = 0; s < 4; s++) begin
        z1 = dly[w.channel_sel][s][0];
        z2 = dly[w.channel_sel][s][1];
        wv = clip40(x - qmul(coef[band][s][3], z1) - qmul(coef[band][s][4], z2));
        yv = clip40(qmul(coef[band][s][0], wv) + qmul(coef[band][s][1], z1)
                    + qmul(coef[band][s][2], z2));
        dly[w.channel_sel][s][1] = z1;
        dly[w.channel_sel][s][0] = wv;
        x = yv;
      end
      ip = x[39:16];
      if (ip > 24'sd32767) r.filtered_out = 16'sh7FFF;
      else if (ip < -24'sd32768) r.filtered_out = 16'sh8000;
      else r.filtered_out = ip[15:0];
      r.channel_out = w.channel_sel;
      expected_q.push_back(r);
    endfunction

    function void check_result(bqc_out_t got);
      bqc_out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word %0d ch %0d", $time,
                 got.filtered_out, got.channel_out);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.filtered_out !== e.filtered_out) begin
        $display("%0t: filtered_out mismatch expected %0d actual %0d", $time,
                 e.filtered_out, got.filtered_out);
        errors++;
      end
      if (got.channel_out !== e.channel_out) begin
        $display("%0t: channel_out mismatch expected %0d actual %0d", $time,
                 e.channel_out, got.channel_out);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  bqc_in_t    in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  bqc_out_t   out_word;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;

  cascade_scoreboard filt_sb = new();
  int send_idle_pct = 0;   // sender gap chance per word
  int recv_stall_pct = 0;  // receiver stall chance per cycle
  int walk[4] = '{2048, 2048, 2048, 2048};  // per-channel slow signal

  biopotential_biquad_cascade_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // receiver stalls at random per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // result monitor: a word moves when valid is high and stall is low
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) filt_sb.check_result(out_word);
  end

  // offer one word, optionally after an idle gap, and wait for acceptance
  task automatic send_word(input logic [11:0] smp, input logic [1:0] ch);
    bqc_in_t w;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    w.sample_in = smp;
    w.channel_sel = ch;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    filt_sb.note_input(w);
  endtask

  // pause the sender until every result is back, then let the core settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (filt_sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // band select may only change while idle
  task automatic set_band(input logic [1:0] m);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    filt_sb.band = m;
  endtask

  // random sample: uniform, rail-to-rail steps, or a slowly moving signal
  task automatic send_random();
    logic [1:0] ch;
    int pick;
    ch = 2'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_word(12'($urandom_range(4095)), ch);
    end else if (pick < 55) begin
      send_word($urandom_range(1) ? 12'hFFF : 12'h000, ch);
    end else begin
      walk[ch] = walk[ch] + $urandom_range(600) - 300;
      if (walk[ch] < 0) walk[ch] = 0;
      if (walk[ch] > 4095) walk[ch] = 4095;
      send_word(12'(walk[ch]), ch);
    end
  endtask

  initial begin
    logic [1:0] band_seq[8] = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0};
    int idle_mix[4] = '{0, 48, 0, 26};
    int stall_mix[4] = '{0, 0, 48, 26};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset band, full-scale steps, zero input, alternating rails, assorted codes
    for (int i = 0; i < 5; i++) send_word(12'hFFF, 2'd0);
    for (int i = 0; i < 3; i++) send_word(12'h000, 2'd1);
    for (int i = 0; i < 8; i++) send_word((i % 2) ? 12'hFFF : 12'h000, 2'd2);
    send_word(12'h800, 2'd3);
    send_word(12'h001, 2'd3);
    send_word(12'hFFE, 2'd3);
    send_word(12'h555, 2'd3);
    send_word(12'hAAA, 2'd3);

    // random phases across every band and idle and stall mix
    for (int p = 0; p < 8; p++) begin
      set_band(band_seq[p]);
      send_idle_pct = idle_mix[p % 4];
      recv_stall_pct = stall_mix[p % 4];
      for (int i = 0; i < 129; i++) begin
        if (p == 2 && i == 60) drain_results();
        send_random();
      end
    end
    in_valid <= 1'b0;

    while (filt_sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (filt_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
